// ===== src/mysql_handshake_classifier_unit_macros.svh =====
// Assertion macros shared by the handshake classifier modules.
`ifndef MYSQL_HANDSHAKE_CLASSIFIER_UNIT_MACROS_SVH
`define MYSQL_HANDSHAKE_CLASSIFIER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MHC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("classifier assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MHC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("classifier assertion failed");

`endif

// ===== src/mhc_pkg.sv =====
// Shared constants and types for the handshake classifier.
package mhc_pkg;

    localparam int unsigned COUNT_BITS_DEF = 16;

    localparam int unsigned LEN_W      = 24;
    localparam int unsigned MIN_LEN    = 49;
    localparam int unsigned GREET_BACK = 26;
    localparam int unsigned FILL_LEN   = 13;
    localparam int unsigned AUTH_START = 13;
    localparam int unsigned AUTH_LEN   = 23;
    localparam int unsigned HDR_BYTES  = 4;

    // Greeting filler window, expressed as offsets added to the byte index.
    localparam int unsigned GREET_LO_OFS = GREET_BACK - HDR_BYTES;
    localparam int unsigned GREET_HI_OFS = GREET_BACK - HDR_BYTES - FILL_LEN + 1;

    localparam logic [7:0]  SEQ_GREETING = 8'd0;
    localparam logic [7:0]  SEQ_AUTH     = 8'd1;
    localparam logic [15:0] APP_LABEL    = 16'd3306;

    typedef struct packed {
        logic matched;
        logic kind;
    } t_result;

endpackage

// ===== src/mysql_handshake_classifier_unit.sv =====
// Top level of the handshake classifier: input stage, tracker and result register.
// o_valid rises once a final byte moves from the input stage into the result register.
// Throughput: one payload byte per cycle while o_stall is low; the input stage and the
// result register let a new byte be taken while a finished result still waits downstream.
// Only a final byte waits for a pending result, and while it waits the input is stalled.
// Reset (synchronous, active low) empties both stages and clears the byte tracker.
module mysql_handshake_classifier_unit #(
    parameter int unsigned COUNT_BITS = mhc_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_matched,
    output logic        o_packet_kind,
    output logic [15:0] o_app_label
);

    logic              r_s1_valid;
    logic [7:0]        r_s1_byte;
    logic              r_s1_last;
    logic              r_out_valid;
    mhc_pkg::t_result  r_out;
    mhc_pkg::t_result  core_result;

    logic out_free, s1_go, s1_free, in_take;

    assign out_free = !r_out_valid || !i_stall;
    // Middle bytes never need the result register, so only a final byte can wait.
    assign s1_go    = r_s1_valid && (!r_s1_last || out_free);
    assign s1_free  = !r_s1_valid || s1_go;
    assign o_stall  = !s1_free;
    assign in_take  = i_valid && s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte <= i_payload_byte;
            r_s1_last <= i_last_byte;
        end
    end

    mhc_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_go),
        .i_byte   (r_s1_byte),
        .i_last   (r_s1_last),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_out <= core_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_matched     = r_out.matched;
    assign o_packet_kind = r_out.kind;
    assign o_app_label   = r_out.matched ? mhc_pkg::APP_LABEL : 16'h0000;

`include "mysql_handshake_classifier_unit_macros.svh"

`MHC_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, s1_go && r_s1_last, o_valid)
`MHC_ASSERT_NEXT(a_blocked_last_held, i_clk, i_rst_n, r_s1_valid && r_s1_last && !out_free, r_s1_valid && r_s1_last)
`MHC_ASSERT_NOW(a_kind_needs_match, i_clk, i_rst_n, o_valid && !o_matched, !o_packet_kind && (o_app_label == 16'h0000))

endmodule

// ===== src/mhc_core.sv =====
// Per-payload state tracking and the match decision for one byte.
module mhc_core #(
    parameter int unsigned COUNT_BITS = mhc_pkg::COUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output mhc_pkg::t_result     o_result
);

    localparam int unsigned CMP_W =
        ((COUNT_BITS > mhc_pkg::LEN_W) ? COUNT_BITS : mhc_pkg::LEN_W) + 1;

    logic [COUNT_BITS-1:0]       r_idx, n_idx;
    logic [mhc_pkg::LEN_W-1:0]   r_len, n_len;
    logic [7:0]                  r_seq, n_seq;
    logic                        r_zok, n_zok;

    logic [COUNT_BITS-1:0]       count;
    logic [CMP_W-1:0]            idx_ext, len_ext, new_len_ext, count_ext;
    logic [CMP_W-1:0]            lo_plus, hi_plus;
    logic                        in_greet, in_auth, hdr_byte;

    assign idx_ext     = CMP_W'(r_idx);
    assign len_ext     = CMP_W'(r_len);
    assign lo_plus     = idx_ext + CMP_W'(mhc_pkg::GREET_LO_OFS);
    assign hi_plus     = idx_ext + CMP_W'(mhc_pkg::GREET_HI_OFS);
    assign in_greet    = (lo_plus >= len_ext) && (hi_plus <= len_ext);
    assign in_auth     = (idx_ext >= CMP_W'(mhc_pkg::AUTH_START)) &&
                         (idx_ext < CMP_W'(mhc_pkg::AUTH_START + mhc_pkg::AUTH_LEN));
    assign hdr_byte    = idx_ext < CMP_W'(mhc_pkg::HDR_BYTES);
    assign count       = (r_idx != {COUNT_BITS{1'b1}}) ? r_idx + COUNT_BITS'(1) : r_idx;

    always_comb begin
        n_len = r_len;
        n_seq = r_seq;
        n_zok = r_zok;
        if (r_idx == COUNT_BITS'(0)) begin
            n_len = {16'h0000, i_byte};
        end else if (r_idx == COUNT_BITS'(1)) begin
            n_len[15:8] = i_byte;
        end else if (r_idx == COUNT_BITS'(2)) begin
            n_len[23:16] = i_byte;
        end else if (r_idx == COUNT_BITS'(3)) begin
            n_seq = i_byte;
        end else if (i_byte != 8'h00) begin
            if ((r_seq == mhc_pkg::SEQ_GREETING) && in_greet) begin
                n_zok = 1'b0;
            end
            if ((r_seq == mhc_pkg::SEQ_AUTH) && in_auth) begin
                n_zok = 1'b0;
            end
        end
        n_idx = count;
    end

    assign new_len_ext = CMP_W'(n_len);
    assign count_ext   = CMP_W'(count);

    always_comb begin
        o_result.matched = (count_ext >= CMP_W'(mhc_pkg::HDR_BYTES)) &&
                           (new_len_ext >= CMP_W'(mhc_pkg::MIN_LEN)) &&
                           (new_len_ext <= count_ext) &&
                           (n_seq <= mhc_pkg::SEQ_AUTH) && n_zok;
        o_result.kind    = o_result.matched & n_seq[0];
    end

    // The final byte of a payload returns the tracker to its reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_len <= '0;
            r_seq <= '0;
            r_zok <= 1'b1;
        end else if (i_step) begin
            if (i_last) begin
                r_idx <= '0;
                r_len <= '0;
                r_seq <= '0;
                r_zok <= 1'b1;
            end else begin
                r_idx <= n_idx;
                r_len <= n_len;
                r_seq <= n_seq;
                r_zok <= n_zok;
            end
        end
    end

`include "mysql_handshake_classifier_unit_macros.svh"

`MHC_ASSERT_NEXT(a_restart_after_last, i_clk, i_rst_n, i_step && i_last, (r_idx == '0) && r_zok)
`MHC_ASSERT_NEXT(a_len_frozen_after_hdr, i_clk, i_rst_n, i_step && !i_last && !hdr_byte, r_len == $past(r_len))
`MHC_ASSERT_NOW(a_short_no_match, i_clk, i_rst_n, hdr_byte && (r_idx != COUNT_BITS'(3)), !o_result.matched)

endmodule
